// ===== hdl/lrgd_pkg.sv =====
`default_nettype none
package lrgd_pkg;

    localparam int MAX_DIM     = 16;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int SIG_SHIFT   = 20 - SIG_IDX_W;
    localparam int T_LIMIT     = 524288;

    localparam logic [1:0] REG_ETA  = 2'd0;
    localparam logic [1:0] REG_NSMP = 2'd1;
    localparam logic [1:0] REG_DIM  = 2'd2;

    localparam logic FUNC_FEATURE = 1'b0;
    localparam logic FUNC_LOAD    = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  weight_index;
        logic [31:0] value;
        logic        label;
    } t_item;

    // long division for the table build
    function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-a in q0.32
    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'h1_0000_0000;
        sum  = 64'h1_0000_0000;
        for (int n = 1; n <= 16; n++) begin
            term = const_div((term * a) >> 32, 64'(n));
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [SIG_ENTRIES*16-1:0] sig_table();
        logic [SIG_ENTRIES*16-1:0] tab;
        logic [63:0] half;
        logic [63:0] full;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] s;
        tab  = '0;
        half = exp_neg((64'd1 << 35) >> SIG_IDX_W);
        full = exp_neg((64'd1 << 36) >> SIG_IDX_W);
        e    = half;
        for (int j = 0; j < SIG_ENTRIES / 2; j++) begin
            d = 64'h1_0000_0000 + e;
            s = const_div((64'd1 << 48) + (d >> 1), d);
            if (s > 64'd65535) begin
                s = 64'd65535;
            end
            tab[(SIG_ENTRIES / 2 + j) * 16 +: 16]     = s[15:0];
            tab[(SIG_ENTRIES / 2 - 1 - j) * 16 +: 16] = 16'(64'd65536 - s);
            e = (e * full + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/logistic_regression_gd_step.sv =====
`default_nettype none
// one batch gradient-descent step of logistic regression. items enter through a small queue;
// a feature element goes through S_DMUL and S_DACC (one shared 48x17 multiplier, product registered
// before accumulation), a sample's last element adds a gradient pass of S_GOP, S_GMUL and S_GACC
// per weight, and the batch's last sample adds S_UDIV, S_UWAIT, S_UMUL and S_UOUT per weight, the
// wait set by the one-bit-a-cycle divide by num_samples. busy rises only when the queue is full.
// results appear one per cycle at most, marked by o_valid for a single cycle, and must be taken at
// once: the receiver cannot stall the block
module logistic_regression_gd_step
    import lrgd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_func,
    input  wire logic [3:0]  i_weight_index,
    input  wire logic [31:0] i_value,
    input  wire logic        i_label,
    output logic             o_valid,
    output logic [3:0]       o_out_index,
    output logic [31:0]      o_out_weight,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] r_eta;
    logic [15:0] r_nsamp;
    logic [4:0]  r_dim;
    t_item       item;
    t_item       head;
    logic        empty;
    logic        pop;

    assign pready = 1'b1;
    assign item   = '{func: i_func, weight_index: i_weight_index, value: i_value,
                      label: i_label};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta   <= 16'd655;
            r_nsamp <= 16'd1;
            r_dim   <= 5'd16;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ETA:  r_eta   <= pwdata[15:0];
                REG_NSMP: r_nsamp <= pwdata[15:0];
                REG_DIM:  r_dim   <= pwdata[4:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ETA:  prdata = {16'd0, r_eta};
            REG_NSMP: prdata = {16'd0, r_nsamp};
            REG_DIM:  prdata = {27'd0, r_dim};
            default:  prdata = '0;
        endcase
    end

    lrgd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_item  (item),
        .o_full  (busy),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    lrgd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .i_eta        (r_eta),
        .i_nsamp      (r_nsamp),
        .i_dim        (r_dim),
        .o_valid      (o_valid),
        .o_out_index  (o_out_index),
        .o_out_weight (o_out_weight),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ===== hdl/lrgd_front.sv =====
`default_nettype none
module lrgd_front
    import lrgd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_head
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH)) else $error("queue overflow");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_ok && !push_ok |=> r_cnt == $past(r_cnt) - 1'b1) else $error("pop lost");
    a_push_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok && !pop_ok |=> r_cnt == $past(r_cnt) + 1'b1) else $error("push lost");
`endif

endmodule
`default_nettype wire

// ===== hdl/lrgd_div.sv =====
`default_nettype none
module lrgd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_dividend,
    input  wire logic [15:0]        i_divisor,
    output logic                    o_done,
    output logic signed [47:0]      o_quotient
);
    logic        r_run;
    logic [5:0]  r_cnt;
    logic [16:0] r_rem;
    logic [47:0] r_quo;
    logic [15:0] r_dvs;
    logic        r_neg;
    logic [16:0] rem_sh;
    logic        fits;

    assign rem_sh     = {r_rem[15:0], r_quo[47]};
    assign fits       = (rem_sh >= {1'b0, r_dvs});
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_neg <= i_dividend[47];
                r_quo <= i_dividend[47] ? 48'(-i_dividend) : i_dividend;
                r_dvs <= (i_divisor == '0) ? 16'd1 : i_divisor;
            end else if (r_run) begin
                r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
                r_quo <= {r_quo[46:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd47) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lrgd_back.sv =====
`default_nettype none
module lrgd_back
    import lrgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire t_item       i_head,
    output logic             o_pop,
    input  wire logic [15:0] i_eta,
    input  wire logic [15:0] i_nsamp,
    input  wire logic [4:0]  i_dim,
    output logic             o_valid,
    output logic [3:0]       o_out_index,
    output logic [31:0]      o_out_weight,
    output logic             o_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_DMUL, S_DACC, S_SIG, S_GOP, S_GMUL, S_GACC,
        S_BATCH, S_UDIV, S_UWAIT, S_UMUL, S_UOUT
    } t_state;

    localparam logic [SIG_ENTRIES*16-1:0] SIG_TAB = sig_table();
    localparam logic signed [47:0] G_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] G_MIN = {1'b1, {47{1'b0}}};

    t_state                 r_state;
    logic signed [31:0]     r_w    [MAX_DIM];
    logic signed [47:0]     r_g    [MAX_DIM];
    logic signed [15:0]     r_buf  [MAX_DIM];
    logic signed [47:0]     r_dot;
    logic [4:0]             r_ecnt;
    logic [15:0]            r_scnt;
    logic [4:0]             r_i;
    logic                   r_label;
    logic                   r_fin;
    logic signed [47:0]     r_ma;
    logic signed [16:0]     r_mb;
    logic signed [63:0]     r_prod;
    logic signed [16:0]     r_tt;
    logic                   r_div_go;

    logic [4:0]             dim;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       waddr;
    logic signed [31:0]     wsel;
    logic signed [64:0]     mul_full;
    logic signed [48:0]     t_val;
    logic [48:0]            t_off;
    logic [SIG_IDX_W-1:0]   sidx;
    logic signed [48:0]     gsum;
    logic signed [40:0]     wdiff;
    logic signed [31:0]     wnew;
    logic                   div_done;
    logic signed [47:0]     div_q;
    logic [15:0]            batch;

    assign dim   = (i_dim == '0) ? 5'd1 : ((i_dim > 5'(MAX_DIM)) ? 5'(MAX_DIM) : i_dim);
    assign batch = (i_nsamp == '0) ? 16'd1 : i_nsamp;
    assign slot  = (r_ecnt >= 5'(MAX_DIM)) ? IDX_W'(MAX_DIM - 1) : r_ecnt[IDX_W-1:0];
    assign waddr = (r_state == S_IDLE) ? slot : r_i[IDX_W-1:0];
    assign wsel  = r_w[waddr];
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign mul_full = r_ma * r_mb;

    assign t_val = r_label ? -49'(r_dot) : 49'(r_dot);
    assign t_off = 49'(t_val + 49'(T_LIMIT));
    always_comb begin
        if (t_val < -49'(T_LIMIT)) begin
            sidx = '0;
        end else if (t_val >= 49'(T_LIMIT)) begin
            sidx = SIG_IDX_W'(SIG_ENTRIES - 1);
        end else begin
            sidx = SIG_IDX_W'(t_off >> SIG_SHIFT);
        end
    end

    assign gsum  = 49'(r_g[r_i[IDX_W-1:0]]) + 49'(r_prod);
    assign wdiff = 41'(wsel) - 41'(r_prod >>> 24);
    always_comb begin
        if (wdiff > 41'sh7FFF_FFFF) begin
            wnew = 32'sh7FFF_FFFF;
        end else if (wdiff < -41'sh8000_0000) begin
            wnew = 32'sh8000_0000;
        end else begin
            wnew = wdiff[31:0];
        end
    end

    lrgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_g[r_i[IDX_W-1:0]]),
        .i_divisor  (batch),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[63:0];
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dot    <= '0;
            r_ecnt   <= '0;
            r_scnt   <= '0;
            r_i      <= '0;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
            o_last   <= 1'b0;
            for (int k = 0; k < MAX_DIM; k++) begin
                r_w[k] <= '0;
                r_g[k] <= '0;
            end
        end else begin
            o_valid  <= 1'b0;
            o_last   <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_head.func == FUNC_LOAD) begin
                            r_w[i_head.weight_index] <= i_head.value;
                        end else begin
                            r_buf[slot] <= i_head.value[15:0];
                            r_ma        <= 48'(wsel);
                            r_mb        <= 17'($signed(i_head.value[15:0]));
                            r_label     <= i_head.label;
                            r_fin       <= (5'(slot) + 5'd1 >= dim);
                            r_ecnt      <= 5'(slot) + 5'd1;
                            r_state     <= S_DMUL;
                        end
                    end
                end
                S_DMUL: r_state <= S_DACC;
                S_DACC: begin
                    r_dot   <= r_dot + 48'(r_prod >>> 8);
                    r_state <= r_fin ? S_SIG : S_IDLE;
                end
                S_SIG: begin
                    r_tt    <= r_label ? -$signed({1'b0, SIG_TAB[sidx*16 +: 16]})
                                       : $signed({1'b0, SIG_TAB[sidx*16 +: 16]});
                    r_dot   <= '0;
                    r_ecnt  <= '0;
                    r_i     <= '0;
                    r_state <= S_GOP;
                end
                S_GOP: begin
                    r_ma    <= 48'(r_buf[r_i[IDX_W-1:0]]);
                    r_mb    <= r_tt;
                    r_state <= S_GMUL;
                end
                S_GMUL: r_state <= S_GACC;
                S_GACC: begin
                    if (gsum > 49'(G_MAX)) begin
                        r_g[r_i[IDX_W-1:0]] <= G_MAX;
                    end else if (gsum < 49'(G_MIN)) begin
                        r_g[r_i[IDX_W-1:0]] <= G_MIN;
                    end else begin
                        r_g[r_i[IDX_W-1:0]] <= gsum[47:0];
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i + 5'd1 == dim) ? S_BATCH : S_GOP;
                end
                S_BATCH: begin
                    r_i <= '0;
                    if (17'(r_scnt) + 17'd1 < 17'(batch)) begin
                        r_scnt  <= r_scnt + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_scnt  <= '0;
                        r_state <= S_UDIV;
                    end
                end
                S_UDIV: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_UWAIT;
                end
                S_UWAIT: begin
                    if (div_done) begin
                        r_ma    <= div_q;
                        r_mb    <= {1'b0, i_eta};
                        r_state <= S_UMUL;
                    end
                end
                S_UMUL: r_state <= S_UOUT;
                S_UOUT: begin
                    r_w[r_i[IDX_W-1:0]] <= wnew;
                    o_valid      <= 1'b1;
                    o_out_index  <= 4'(r_i);
                    o_out_weight <= wnew;
                    r_i          <= r_i + 1'b1;
                    if (r_i + 5'd1 == dim) begin
                        o_last  <= 1'b1;
                        r_state <= S_IDLE;
                        for (int k = 0; k < MAX_DIM; k++) begin
                            r_g[k] <= '0;
                        end
                    end else begin
                        r_state <= S_UDIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_UOUT)) else $error("stray result");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> r_scnt == '0 && r_g[0] == '0) else $error("batch not closed");
    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UWAIT && div_done |=> r_state == S_UMUL) else $error("divide lost");
    a_ecnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= 5'(MAX_DIM)) else $error("element count range");
`endif

endmodule
`default_nettype wire
